@@ design/pd_line_follow_steering_assert.svh @@
// Assertion macros for the line follower steering block.
`ifndef PD_LINE_FOLLOW_STEERING_ASSERT_SVH
`define PD_LINE_FOLLOW_STEERING_ASSERT_SVH
`ifndef ASSERT_OFF
`define PDLF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define PDLF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define PDLF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define PDLF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

@@ design/pdlf_pkg.sv @@
// Shared widths, register indexes and command bundle for the line follower.
`timescale 1ns / 1ps
package pdlf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DRIVE_W  = 15;
  localparam int POS_W    = 4;
  localparam int STEP_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_EN  = 3'd4;

  localparam logic signed [POS_W-1:0] POS_CENTER   = 4'sd0;
  localparam logic signed [POS_W-1:0] POS_LEFT     = 4'sd1;
  localparam logic signed [POS_W-1:0] POS_RIGHT    = -4'sd1;
  localparam logic signed [POS_W-1:0] POS_LOST     = 4'sd5;
  localparam logic signed [POS_W-1:0] POS_LOST_NEG = -4'sd5;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_p;
    logic mul_d;
    logic acc_add;
    logic clamp;
    logic out_load;
  } pdlf_cmd_t;

endpackage

@@ design/pd_line_follow_steering.sv @@
// Top level of the two-sensor PD line follower steering block.
//
//   channel | direction | handshake            | beat carries
//   in      | input     | in_valid/in_ready    | left and right sensor samples
//   out     | output    | out_valid/out_ready  | drives, line position, correction
//   cfg     | input     | cfg_valid/cfg_ready  | register index and write data
//
// A result is formed by 4 divider steps, two passes of the shared multiplier, an accumulate,
// a clamp and the output load; a new beat is taken only once the earlier item is loaded.
// The four-step serial divider and the single shared multiplier set this sequence.
// Reset is synchronous and restores the register defaults and the tracking state.
// The output register holds a result until taken; a new beat is accepted meanwhile, and
// only the output load waits if the earlier result is still pending.
`timescale 1ns / 1ps
`include "pd_line_follow_steering_assert.svh"
module pd_line_follow_steering import pdlf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_W-1:0]        in_left_sample,
  input  logic [SAMPLE_W-1:0]        in_right_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DRIVE_W-1:0]  out_right_drive,
  output logic signed [DRIVE_W-1:0]  out_left_drive,
  output logic signed [POS_W-1:0]    out_line_position,
  output logic signed [DRIVE_W-1:0]  out_correction,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  pdlf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  pdlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pdlf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_left_sample    (in_left_sample),
    .in_right_sample   (in_right_sample),
    .out_right_drive   (out_right_drive),
    .out_left_drive    (out_left_drive),
    .out_line_position (out_line_position),
    .out_correction    (out_correction)
  );

  // The drives differ by twice the correction, since both derive from one base.
  `PDLF_ASSERT_IMP(a_drive_split, clk, rst_n, out_valid, (16'(out_left_drive) - 16'(out_right_drive)) == 16'(out_correction) * 16'sd2, "drive difference does not match correction")
  `PDLF_ASSERT_IMP(a_pos_legal, clk, rst_n, out_valid, out_line_position == POS_CENTER || out_line_position == POS_LEFT || out_line_position == POS_RIGHT || out_line_position == POS_LOST || out_line_position == POS_LOST_NEG, "illegal line position")
  `PDLF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while an item is in flight")

endmodule

@@ design/pdlf_ctrl.sv @@
// Sequencer that steps one sample pair through divide, multiply and clamp.
`timescale 1ns / 1ps
module pdlf_ctrl import pdlf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pdlf_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_MULP  = 7'b0000100,
    S_MULD  = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_CLAMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_MULP;
        end
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Wait here only while the previous result is still unclaimed.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/pdlf_dp.sv @@
// Datapath: settings, position state, serial divider, shared multiplier, clamp.
`timescale 1ns / 1ps
module pdlf_dp import pdlf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdlf_cmd_t                   cmd,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic [SAMPLE_W-1:0]         in_left_sample,
  input  logic [SAMPLE_W-1:0]         in_right_sample,
  output logic signed [DRIVE_W-1:0]   out_right_drive,
  output logic signed [DRIVE_W-1:0]   out_left_drive,
  output logic signed [POS_W-1:0]     out_line_position,
  output logic signed [DRIVE_W-1:0]   out_correction
);

  // Settings.
  logic [9:0]  thr_r;
  logic [7:0]  kp_r;
  logic [9:0]  kd_r;
  logic [11:0] base_r;
  logic        clamp_en_r;

  // Tracking state.
  logic signed [POS_W-1:0] last_r;
  logic [STEP_W-1:0]       step_r;
  logic                    chg_r;

  // Per-item work registers.
  logic signed [POS_W-1:0] pos_r;
  logic [3:0]              dvd_r;
  logic [STEP_W-1:0]       dvs_r;
  logic [STEP_W-1:0]       rem_r;
  logic [3:0]              quo_r;
  logic                    neg_r;
  logic signed [15:0]      prod_r;
  logic signed [DRIVE_W-1:0] acc_r;
  logic signed [DRIVE_W-1:0] corr_r;

  logic signed [DRIVE_W-1:0] rdrv_r, ldrv_r, ocorr_r;
  logic signed [POS_W-1:0]   opos_r;

  logic                    lon, ron;
  logic signed [POS_W-1:0] pos_c;
  logic [STEP_W-1:0]       step_inc;
  logic signed [4:0]       diff;
  logic [4:0]              diff_mag;
  logic [STEP_W:0]         rem_sh;
  logic                    rem_ge;
  logic signed [4:0]       deriv;
  logic signed [10:0]      mul_a;
  logic signed [4:0]       mul_b;
  logic signed [15:0]      prod;
  logic signed [DRIVE_W-1:0] base_s;
  logic signed [DRIVE_W-1:0] clamp_c;

  assign lon = (in_left_sample >= thr_r);
  assign ron = (in_right_sample >= thr_r);

  always_comb begin
    priority if (lon && ron) begin
      pos_c = POS_CENTER;
    end else if (lon) begin
      pos_c = POS_LEFT;
    end else if (ron) begin
      pos_c = POS_RIGHT;
    end else if (last_r < 0) begin
      pos_c = POS_LOST_NEG;
    end else begin
      pos_c = POS_LOST;
    end
  end

  assign step_inc = (step_r != {STEP_W{1'b1}}) ? step_r + 1'b1 : step_r;
  assign diff     = {pos_c[POS_W-1], pos_c} - {last_r[POS_W-1], last_r};
  assign diff_mag = diff[4] ? 5'(-diff) : 5'(diff);

  // Restoring divide, one quotient bit per step; the remainder stays below the divisor.
  assign rem_sh = {rem_r, dvd_r[3]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_r});

  assign deriv = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  assign mul_a = cmd.mul_d ? $signed({1'b0, kd_r}) : $signed({3'b000, kp_r});
  assign mul_b = cmd.mul_d ? deriv : $signed({pos_r[POS_W-1], pos_r});
  assign prod  = mul_a * mul_b;

  assign base_s = $signed({3'b000, base_r});

  always_comb begin
    clamp_c = acc_r;
    if (clamp_en_r) begin
      if (acc_r > base_s) begin
        clamp_c = base_s;
      end else if (acc_r < -base_s) begin
        clamp_c = -base_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= 10'd512;
      kp_r       <= '0;
      kd_r       <= '0;
      base_r     <= '0;
      clamp_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r      <= cfg_data[9:0];
        CFG_KP_GAIN:   kp_r       <= cfg_data[7:0];
        CFG_KD_GAIN:   kd_r       <= cfg_data[9:0];
        CFG_BASE:      base_r     <= cfg_data[11:0];
        CFG_CLAMP_EN:  clamp_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The step and change counters clear on every second position change.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      step_r <= '0;
      chg_r  <= 1'b0;
    end else if (cmd.load) begin
      last_r <= pos_c;
      if ((pos_c != last_r) && chg_r) begin
        step_r <= '0;
        chg_r  <= 1'b0;
      end else begin
        step_r <= step_inc;
        if (pos_c != last_r) begin
          chg_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= pos_c;
      dvd_r <= diff_mag[3:0];
      neg_r <= diff[4];
      dvs_r <= step_inc;
      rem_r <= '0;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[2:0], 1'b0};
      quo_r <= {quo_r[2:0], rem_ge};
      rem_r <= rem_ge ? STEP_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[STEP_W-1:0];
    end
    if (cmd.mul_p || cmd.mul_d) begin
      prod_r <= prod;
    end
    if (cmd.mul_d) begin
      acc_r <= prod_r[DRIVE_W-1:0];
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r[DRIVE_W-1:0];
    end
    if (cmd.clamp) begin
      corr_r <= clamp_c;
    end
    if (cmd.out_load) begin
      rdrv_r  <= base_s - corr_r;
      ldrv_r  <= base_s + corr_r;
      ocorr_r <= corr_r;
      opos_r  <= pos_r;
    end
  end

  assign out_right_drive   = rdrv_r;
  assign out_left_drive    = ldrv_r;
  assign out_line_position = opos_r;
  assign out_correction    = ocorr_r;

endmodule
